// File: hdl/tfs_pkg.sv
// Shared types, constants and the divide-by-ten helper for the telemetry frame serializer.
// No dependencies; imported by tfs_serializer and telemetry_frame_serializer_top.
`default_nettype none

package tfs_pkg;

	localparam int unsigned TickW    = 16;
	localparam int unsigned RpmW     = 16;
	localparam int unsigned SpeedW   = 14;
	localparam int unsigned CurrentW = 17;
	localparam int unsigned ByteW    = 8;
	localparam int unsigned PosW     = 4;
	localparam int unsigned QuotW    = 14;
	localparam int unsigned ProdW    = 36;

	localparam logic [TickW-1:0]    COMPARE_RESET = 16'd2000;
	localparam logic [SpeedW-1:0]   SPEED_MAX     = 14'd9999;
	localparam logic [CurrentW-1:0] CURRENT_MAX   = 17'd99999;
	localparam logic [ByteW-1:0]    FRAME_DELIM   = 8'h1B;
	localparam logic [ByteW-1:0]    ASCII_ZERO    = 8'h30;

	// byte positions within a frame
	localparam logic [PosW-1:0] POS_RPM_END   = 4'd2;
	localparam logic [PosW-1:0] POS_SPEED_END = 4'd6;
	localparam logic [PosW-1:0] POS_DELIM     = 4'd12;

	// ceil(2^22 / 10); exact quotient for every value below 2^17
	localparam logic [18:0] DIV10_MUL = 19'd419431;

	typedef struct packed {
		logic [RpmW-1:0]     rpm;
		logic [SpeedW-1:0]   speed_centi;
		logic [CurrentW-1:0] current_milli;
	} frame_req_t;

	typedef struct packed {
		logic [QuotW-1:0] quot;
		logic [3:0]       rem;
	} digit_split_t;

	function automatic digit_split_t split_digit(input logic [CurrentW-1:0] v);
		logic [ProdW-1:0]    prod;
		logic [CurrentW-1:0] tenfold;
		digit_split_t        r;
		prod    = ProdW'(v) * ProdW'(DIV10_MUL);
		r.quot  = prod[35:22];
		tenfold = CurrentW'({r.quot, 3'b000}) + CurrentW'({r.quot, 1'b0});
		r.rem   = 4'(v - tenfold);
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/tfs_serializer.sv
// Frame serializer: splits rpm, speed and current into ASCII digits, one byte per cycle unless out_stall holds it.
// Depends on tfs_pkg (frame_req_t, split_digit, frame constants).
`default_nettype none

module tfs_serializer
	import tfs_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_ready,
	input  wire frame_req_t       req,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [ByteW-1:0]      frame_byte,
	output logic                  last
);

	logic                busy_q;
	logic [PosW-1:0]     pos_q;
	logic [CurrentW-1:0] val_q;
	logic [SpeedW-1:0]   speed_q;
	logic [CurrentW-1:0] current_q;
	logic                out_valid_q;
	logic [ByteW-1:0]    byte_q;
	logic                last_q;

	digit_split_t        split;
	logic                out_free;
	logic                adv;
	logic                load;

	assign split    = split_digit(val_q);
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = busy_q && out_free;
	assign load     = req_valid && (!busy_q || (adv && pos_q == POS_DELIM));
	assign req_ready = !busy_q || (adv && pos_q == POS_DELIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free)
				out_valid_q <= busy_q;
			if (load) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end else if (adv) begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == POS_DELIM)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pos_q == POS_DELIM) begin
				byte_q <= FRAME_DELIM;
				last_q <= 1'b1;
			end else begin
				byte_q <= ASCII_ZERO + ByteW'(split.rem);
				last_q <= 1'b0;
			end
		end
		if (load) begin
			val_q     <= CurrentW'(req.rpm);
			speed_q   <= req.speed_centi;
			current_q <= req.current_milli;
		end else if (adv) begin
			case (pos_q)
				POS_RPM_END:   val_q <= CurrentW'(speed_q);
				POS_SPEED_END: val_q <= current_q;
				default:       val_q <= CurrentW'(split.quot);
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = byte_q;
	assign last       = last_q;

endmodule

`default_nettype wire

// File: hdl/telemetry_frame_serializer_top.sv
// Top level of the telemetry frame serializer: tick counter, compare register, request stage.
// Depends on tfs_pkg and tfs_serializer.
//
// Usage:
//  - Input channel (in_valid / in_stall): one transaction per prescaled timer tick, carrying
//    send_enable, rpm, speed_centi and current_milli. Ticks are taken every cycle while no
//    frame waits in the request stage.
//  - Counter clears on a match with compare_value; a match with send_enable set queues a
//    13-byte frame: 3 rpm digits, 4 speed digits, 5 current digits (LSD first), then 0x1B.
//  - Output channel (out_valid / out_stall): one transaction per frame byte; last marks 0x1B.
//  - Idle path: tick to request stage, to splitter load, to first byte in the output register.
//  - Throughput: one byte per cycle while out_stall is low, set by the single digit splitter.
//    One further frame may wait in the request stage; while it waits and the splitter
//    cannot take it, in_stall holds every tick, frame or not.
//  - Configuration (cfg_valid / cfg_ready / compare_value): always ready; write while idle.
//  - Reset: counter to 0, compare register to 2000, no frame pending.
//  - Receiver stall: the current byte holds; the splitter pauses until it is taken.
`default_nettype none

module telemetry_frame_serializer_top
	import tfs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [TickW-1:0]    compare_value,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                send_enable,
	input  wire logic [RpmW-1:0]     rpm,
	input  wire logic [SpeedW-1:0]   speed_centi,
	input  wire logic [CurrentW-1:0] current_milli,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [ByteW-1:0]         frame_byte,
	output logic                     last
);

	logic [TickW-1:0] compare_q;
	logic [TickW-1:0] tick_q;
	logic             req_valid_s1;
	frame_req_t       req_s1;
	logic             req_ready;
	logic             accept;
	logic             match;
	frame_req_t       req_in;

	assign cfg_ready = 1'b1;
	assign in_stall  = req_valid_s1 && !req_ready;
	assign accept    = in_valid && !in_stall;
	assign match     = (tick_q == compare_q);

	always_comb begin
		req_in.rpm           = rpm;
		req_in.speed_centi   = (speed_centi > SPEED_MAX) ? SPEED_MAX : speed_centi;
		req_in.current_milli = (current_milli > CURRENT_MAX) ? CURRENT_MAX : current_milli;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compare_q    <= COMPARE_RESET;
			tick_q       <= '0;
			req_valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				compare_q <= compare_value;
			if (req_ready)
				req_valid_s1 <= 1'b0;
			if (accept) begin
				if (match) begin
					tick_q <= '0;
					if (send_enable)
						req_valid_s1 <= 1'b1;
				end else begin
					tick_q <= tick_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && match && send_enable)
			req_s1 <= req_in;
	end

	tfs_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid_s1),
		.req_ready  (req_ready),
		.req        (req_s1),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last       (last)
	);

endmodule

`default_nettype wire

// File: bench/tfs_frame_checker.sv
// Checker for the telemetry frame serializer: follows the compare register and tick counter,
// predicts every frame byte from accepted ticks and compares what the block emits.
// Depends on tfs_pkg; instantiated beside the block by telemetry_frame_serializer_top_test.
module tfs_frame_checker
	import tfs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [TickW-1:0]    compare_value,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                send_enable,
	input  logic [RpmW-1:0]     rpm,
	input  logic [SpeedW-1:0]   speed_centi,
	input  logic [CurrentW-1:0] current_milli,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [ByteW-1:0]    frame_byte,
	input  logic                last,
	output int unsigned         pending,
	output int unsigned         failures
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [ByteW-1:0] data;
		logic             tail;
	} coded_byte_t;

	coded_byte_t      bytes_due[$];
	logic [TickW-1:0] cmp_model;
	logic [TickW-1:0] tick_model;

	initial failures = 0;

	task automatic note_mismatch(input string what);
		failures++;
		$display("%0t ns: %s", $time, what);
	endtask

	function automatic void push_digits(input int unsigned v, input int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			bytes_due.push_back('{data: ASCII_ZERO + ByteW'(v % 10), tail: 1'b0});
			v = v / 10;
		end
	endfunction

	task automatic predict_tick();
		int unsigned spd;
		int unsigned cur;
		if (tick_model != cmp_model) begin
			tick_model = tick_model + 1'b1;
		end else begin
			tick_model = '0;
			if (send_enable) begin
				spd = speed_centi;
				cur = current_milli;
				if (spd > SPEED_MAX)
					spd = SPEED_MAX;
				if (cur > CURRENT_MAX)
					cur = CURRENT_MAX;
				push_digits(rpm % 1000, 3);
				push_digits(spd, 4);
				push_digits(cur, 5);
				bytes_due.push_back('{data: FRAME_DELIM, tail: 1'b1});
			end
		end
	endtask

	task automatic check_byte();
		coded_byte_t want;
		if (bytes_due.size() == 0) begin
			note_mismatch($sformatf("byte %h (last %b) with no frame due", frame_byte, last));
		end else begin
			want = bytes_due.pop_front();
			if (frame_byte !== want.data)
				note_mismatch($sformatf("frame_byte %h, want %h", frame_byte, want.data));
			if (last !== want.tail)
				note_mismatch($sformatf("last %b, want %b on byte %h", last, want.tail,
					want.data));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_model  = COMPARE_RESET;
			tick_model = '0;
			bytes_due.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				cmp_model = compare_value;
			if (in_valid && !in_stall)
				predict_tick();
			if (out_valid && !out_stall)
				check_byte();
			pending <= bytes_due.size();
		end
	end

endmodule

// File: bench/telemetry_frame_serializer_top_test.sv
// Stimulus and verdict for telemetry_frame_serializer_top: drives ticks and compare writes
// through several compare settings; checking is left to tfs_frame_checker.
// Depends on tfs_pkg, tfs_frame_checker and the serializer RTL.
module telemetry_frame_serializer_top_test
	import tfs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [TickW-1:0]    cfg_compare = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                send_enable = 1'b0;
	logic [RpmW-1:0]     rpm = '0;
	logic [SpeedW-1:0]   speed_centi = '0;
	logic [CurrentW-1:0] current_milli = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [ByteW-1:0]    frame_byte;
	logic                last;
	int unsigned         pending;
	int unsigned         failures;

	logic             calm = 1'b0;
	logic [TickW-1:0] tick_pos = '0;
	logic [TickW-1:0] cmp_now = COMPARE_RESET;

	telemetry_frame_serializer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.compare_value (cfg_compare),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.send_enable   (send_enable),
		.rpm           (rpm),
		.speed_centi   (speed_centi),
		.current_milli (current_milli),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_byte    (frame_byte),
		.last          (last)
	);

	tfs_frame_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.compare_value (cfg_compare),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.send_enable   (send_enable),
		.rpm           (rpm),
		.speed_centi   (speed_centi),
		.current_milli (current_milli),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.frame_byte    (frame_byte),
		.last          (last),
		.pending       (pending),
		.failures      (failures)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 28);

	function automatic logic [RpmW-1:0] rand_rpm();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return RpmW'($urandom_range(998, 1001));
			default: return RpmW'($urandom);
		endcase
	endfunction

	function automatic logic [SpeedW-1:0] rand_speed();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return SpeedW'($urandom_range(9998, 10001));
			default: return SpeedW'($urandom);
		endcase
	endfunction

	function automatic logic [CurrentW-1:0] rand_current();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return CurrentW'($urandom_range(99998, 100001));
			default: return CurrentW'($urandom);
		endcase
	endfunction

	task automatic send_tick(input logic en, input logic [RpmW-1:0] r,
		input logic [SpeedW-1:0] s, input logic [CurrentW-1:0] c);
		while (!calm && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		send_enable   <= en;
		rpm           <= r;
		speed_centi   <= s;
		current_milli <= c;
		do @(posedge clk); while (in_stall);
		tick_pos = (tick_pos == cmp_now) ? '0 : tick_pos + 1'b1;
	endtask

	task automatic random_ticks(input int n);
		for (int i = 0; i < n; i++)
			send_tick($urandom_range(99) < 80, rand_rpm(), rand_speed(), rand_current());
	endtask

	// run up to and including the next compare match, which always sends
	task automatic run_to_match();
		int n;
		if (tick_pos <= cmp_now)
			n = int'(cmp_now) - int'(tick_pos) + 1;
		else
			n = 65536 - int'(tick_pos) + int'(cmp_now) + 1;
		for (int i = 0; i < n; i++)
			send_tick((i == n - 1) || $urandom_range(1), rand_rpm(), rand_speed(),
				rand_current());
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_compare(input logic [TickW-1:0] v);
		settle();
		cfg_valid   <= 1'b1;
		cfg_compare <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cmp_now = v;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset compare value: counter only climbs, no frames; then a match at the count reached sends one
		random_ticks(20);
		write_compare(tick_pos);
		run_to_match();

		// compare zero: every tick matches
		write_compare('0);
		send_tick(1'b1, '0, '0, '0);
		send_tick(1'b1, '1, '1, '1);
		send_tick(1'b1, 16'd999, 14'd9999, 17'd99999);
		send_tick(1'b1, 16'd1000, 14'd10000, 17'd100000);
		send_tick(1'b0, 16'd123, 14'd4567, 17'd89012);
		send_tick(1'b1, 16'd12345, 14'd1234, 17'd12345);
		send_tick(1'b1, 16'h5555, 14'h2AAA, 17'h15555);
		send_tick(1'b1, 16'hAAAA, 14'h1555, 17'h0AAAA);
		send_tick(1'b0, '1, '1, '1);
		send_tick(1'b1, 16'd65000, 14'd10, 17'd100);
		random_ticks(60);

		calm <= 1'b1;
		write_compare(16'd1);
		random_ticks(100);
		calm <= 1'b0;
		write_compare(16'd2);
		random_ticks(80);
		write_compare(16'd3);
		random_ticks(100);
		write_compare(16'd6);
		random_ticks(50);

		settle();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("telemetry_frame_serializer_top: match");
		else
			$display("telemetry_frame_serializer_top: mismatch");
		$finish;
	end

	initial begin
		#6_000_000;
		$display("telemetry_frame_serializer_top: mismatch");
		$finish;
	end

endmodule
